### rtl/frame_rate_jitter_monitor_assert.svh
// Assertion macros shared by the frame rate and jitter monitor RTL.
`ifndef FRAME_RATE_JITTER_MONITOR_ASSERT_SVH
`define FRAME_RATE_JITTER_MONITOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define FRJM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define FRJM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/frjm_pkg.sv
// Shared constants and types for the frame rate and jitter monitor.
`default_nettype none

package frjm_pkg;

  localparam int QUEUE_DEPTH_DEF = 10;
  localparam int TIME_BITS_DEF   = 48;

  localparam int CNT_W  = 16;
  localparam int TPS_W  = 32;
  localparam int LIM_W  = 16;
  localparam int RATE_W = 32;
  localparam int FRAC_W = 16;
  localparam int RIDX_W = 4;
  localparam int NUM_W  = CNT_W + TPS_W + FRAC_W;

  localparam logic [TPS_W-1:0] TPS_RESET    = TPS_W'(10000000);
  localparam longint unsigned  WINDOW_RESET = 64'd5000000;
  localparam logic [LIM_W-1:0] LIMIT_RESET  = LIM_W'(1966);
  localparam longint unsigned  EXPIRY_RESET = 64'd30000000;

  localparam logic [1:0] REG_TPS    = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;
  localparam logic [1:0] REG_EXPIRY = 2'd3;

  localparam logic ACT_FRAME = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } frjm_unit_stat_t;

endpackage

`default_nettype wire

### rtl/frame_rate_jitter_monitor.sv
// Top level of the frame rate and jitter monitor.
`default_nettype none
`include "frame_rate_jitter_monitor_assert.svh"

// Frame rate and jitter monitor.
// Input items arrive on in_valid/in_ready. An item with action 0 is a frame
// event carrying its tick timestamp; an item with action 1 reads one slot of
// the jitter history. Each item yields exactly one result item on
// out_valid/out_ready, in order.
// A read goes straight to the final step, which loads its result into the
// output register. A frame event runs through the 16-step bit-serial
// multipliers and then the difference and compare steps; when it closes a
// rate window, the rate quotient also comes out of a radix-2 divider at one
// bit per cycle over its 64-bit dividend. The block works on one item at a
// time and takes the next item once a result is in the output register.
// The output register holds one finished result; while the receiver stalls,
// the block still accepts and works on the next item and then waits with it
// until the output register is free.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// must only be changed while the block is idle.
// Synchronous reset empties the history, zeroes all counters and the rate,
// restores the register defaults and leaves the output register empty.
module frame_rate_jitter_monitor #(
  parameter int QUEUE_DEPTH = frjm_pkg::QUEUE_DEPTH_DEF,
  parameter int TIME_BITS   = frjm_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [TIME_BITS-1:0]          cfg_data,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [TIME_BITS-1:0]          timestamp,
  input  wire logic [frjm_pkg::RIDX_W-1:0]   read_index,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [frjm_pkg::RATE_W-1:0]   fps_q16,
  output logic                               jitter_logged,
  output logic      [TIME_BITS-1:0]          period_ticks,
  output logic                               entry_valid,
  output logic      [TIME_BITS-1:0]          entry_period_ticks,
  output logic      [frjm_pkg::RATE_W-1:0]   entry_fps_q16
);

  localparam int CNT_W  = frjm_pkg::CNT_W;
  localparam int TPS_W  = frjm_pkg::TPS_W;
  localparam int LIM_W  = frjm_pkg::LIM_W;
  localparam int RATE_W = frjm_pkg::RATE_W;
  localparam int FRAC_W = frjm_pkg::FRAC_W;
  localparam int RIDX_W = frjm_pkg::RIDX_W;
  localparam int NUM_W  = frjm_pkg::NUM_W;
  // Width of period*count and limit*delta, and of the shifted deviation.
  localparam int PW     = TIME_BITS + CNT_W;
  localparam int LW     = PW + FRAC_W;
  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RX_W   = ((IDX_W > RIDX_W) ? IDX_W : RIDX_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_ABS  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // Configuration registers.
  logic [TPS_W-1:0]     tps;
  logic [TIME_BITS-1:0] window_ticks;
  logic [LIM_W-1:0]     dev_limit;
  logic [TIME_BITS-1:0] expiry_ticks;

  // Rate window state.
  logic [CNT_W-1:0]     frame_count;
  logic [TIME_BITS-1:0] window_start;
  logic [TIME_BITS-1:0] last_frame_time;
  logic [RATE_W-1:0]    rate_value;
  logic [CNT_W-1:0]     window_count;
  logic [TIME_BITS-1:0] window_delta;

  // Jitter history; index QUEUE_DEPTH-1 is the newest entry. The written
  // bits keep never-filled slots reading as zero even after entries expire.
  logic                 hist_valid   [QUEUE_DEPTH];
  logic                 hist_written [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] hist_time    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] hist_period  [QUEUE_DEPTH];
  logic [RATE_W-1:0]    hist_rate    [QUEUE_DEPTH];

  // Per-item working registers.
  logic [2:0]           state;
  logic                 act_reg;
  logic [TIME_BITS-1:0] ts_reg;
  logic [RIDX_W-1:0]    ridx_reg;
  logic                 upd_reg;
  logic [TIME_BITS-1:0] period_reg;
  logic [PW-1:0]        diff_reg;
  logic                 logged_reg;

  // Frame preparation logic.
  logic [CNT_W-1:0]     fc_inc;
  logic [TIME_BITS-1:0] elapsed;
  logic                 upd;
  logic [CNT_W-1:0]     wcount_new;
  logic [TIME_BITS-1:0] wdelta_new;
  logic [TIME_BITS-1:0] period;
  logic                 expire [QUEUE_DEPTH];

  // Arithmetic units.
  logic                      mul_start;
  logic [TPS_W+CNT_W-1:0]    prod_rate;
  logic [PW-1:0]             prod_per;
  logic [PW-1:0]             prod_lim;
  frjm_pkg::frjm_unit_stat_t mul_rate_stat;
  frjm_pkg::frjm_unit_stat_t mul_per_stat;
  frjm_pkg::frjm_unit_stat_t mul_lim_stat;
  logic                      div_start;
  logic [RATE_W-1:0]         div_q;
  frjm_pkg::frjm_unit_stat_t div_stat;

  // History read port.
  logic [RX_W-1:0]  ridx_ext;
  logic [IDX_W-1:0] slot;
  logic             in_range;
  logic             rd_valid;
  logic [TIME_BITS-1:0] rd_period;
  logic [RATE_W-1:0]    rd_rate;

  logic in_fire;
  logic out_free;
  logic load_out;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign load_out = (state == S_DONE) && out_free;

  // The frame count saturates; a window closes only when time has moved
  // forward by at least window_ticks, and never on zero elapsed time.
  always_comb begin
    fc_inc     = (frame_count == '1) ? frame_count : frame_count + CNT_W'(1);
    elapsed    = ts_reg - window_start;
    upd        = (ts_reg >= window_start) && (elapsed != '0) &&
                 (elapsed >= window_ticks);
    wcount_new = upd ? fc_inc : window_count;
    wdelta_new = upd ? elapsed : window_delta;
    period     = ts_reg - last_frame_time;
  end

  // An entry whose time lies ahead of the frame's timestamp never expires.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      expire[i] = hist_valid[i] && (ts_reg >= hist_time[i]) &&
                  ((ts_reg - hist_time[i]) > expiry_ticks);
    end
  end

  assign mul_start = (state == S_PREP);
  assign div_start = (state == S_CMP) && upd_reg;

  // count * ticks_per_second; the Q16 scale is a plain shift of the dividend.
  frjm_mul #(.A_W(TPS_W), .B_W(CNT_W)) u_mul_rate (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (tps),
    .b       (fc_inc),
    .product (prod_rate),
    .stat    (mul_rate_stat)
  );

  // Frame period times the window's frame count.
  frjm_mul #(.A_W(TIME_BITS), .B_W(CNT_W)) u_mul_per (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (period),
    .b       (wcount_new),
    .product (prod_per),
    .stat    (mul_per_stat)
  );

  // Deviation limit times the window length.
  frjm_mul #(.A_W(TIME_BITS), .B_W(LIM_W)) u_mul_lim (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (wdelta_new),
    .b       (dev_limit),
    .product (prod_lim),
    .stat    (mul_lim_stat)
  );

  frjm_div #(.NUM_W(NUM_W), .DEN_W(TIME_BITS), .Q_W(RATE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      ({prod_rate, FRAC_W'(0)}),
    .den      (window_delta),
    .quotient (div_q),
    .stat     (div_stat)
  );

  // Indexes past the end of the history read back as an empty entry.
  always_comb begin
    ridx_ext  = RX_W'(ridx_reg);
    in_range  = ridx_ext < RX_W'(QUEUE_DEPTH);
    slot      = ridx_ext[IDX_W-1:0];
    rd_valid  = 1'b0;
    rd_period = '0;
    rd_rate   = '0;
    if (in_range && hist_written[slot]) begin
      rd_valid  = hist_valid[slot];
      rd_period = hist_period[slot];
      rd_rate   = hist_rate[slot];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tps          <= frjm_pkg::TPS_RESET;
      window_ticks <= TIME_BITS'(frjm_pkg::WINDOW_RESET);
      dev_limit    <= frjm_pkg::LIMIT_RESET;
      expiry_ticks <= TIME_BITS'(frjm_pkg::EXPIRY_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        frjm_pkg::REG_TPS:    tps          <= cfg_data[TPS_W-1:0];
        frjm_pkg::REG_WINDOW: window_ticks <= cfg_data;
        frjm_pkg::REG_LIMIT:  dev_limit    <= cfg_data[LIM_W-1:0];
        frjm_pkg::REG_EXPIRY: expiry_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and block state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      frame_count     <= '0;
      window_start    <= '0;
      last_frame_time <= '0;
      rate_value      <= '0;
      window_count    <= '0;
      window_delta    <= '0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        hist_valid[i]   <= 1'b0;
        hist_written[i] <= 1'b0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= (action == frjm_pkg::ACT_READ) ? S_DONE : S_PREP;
          end
        end
        S_PREP: begin
          // Window bookkeeping and expiry are committed here; the units
          // pick up their operands in the same cycle.
          if (upd) begin
            window_count <= fc_inc;
            window_delta <= elapsed;
            frame_count  <= '0;
            window_start <= ts_reg;
          end else begin
            frame_count <= fc_inc;
          end
          last_frame_time <= ts_reg;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (expire[i]) begin
              hist_valid[i] <= 1'b0;
            end
          end
          state <= S_MUL;
        end
        S_MUL: begin
          if (mul_per_stat.done) begin
            state <= S_ABS;
          end
        end
        S_ABS: begin
          state <= S_CMP;
        end
        S_CMP: begin
          state <= upd_reg ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_stat.done) begin
            rate_value <= div_q;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (act_reg == frjm_pkg::ACT_FRAME && logged_reg) begin
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                hist_valid[i]   <= hist_valid[i+1];
                hist_written[i] <= hist_written[i+1];
              end
              hist_valid[QUEUE_DEPTH-1]   <= 1'b1;
              hist_written[QUEUE_DEPTH-1] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers of the history and of the working item.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_reg  <= action;
      ts_reg   <= timestamp;
      ridx_reg <= read_index;
    end
    if (state == S_PREP) begin
      upd_reg    <= upd;
      period_reg <= period;
    end
    if (state == S_ABS) begin
      diff_reg <= (prod_per >= PW'(window_delta)) ? prod_per - PW'(window_delta)
                                                  : PW'(window_delta) - prod_per;
    end
    if (state == S_CMP) begin
      logged_reg <= {diff_reg, FRAC_W'(0)} >= LW'(prod_lim);
    end
    if (load_out && act_reg == frjm_pkg::ACT_FRAME && logged_reg) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        hist_time[i]   <= hist_time[i+1];
        hist_period[i] <= hist_period[i+1];
        hist_rate[i]   <= hist_rate[i+1];
      end
      hist_time[QUEUE_DEPTH-1]   <= ts_reg;
      hist_period[QUEUE_DEPTH-1] <= period_reg;
      hist_rate[QUEUE_DEPTH-1]   <= rate_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      fps_q16 <= rate_value;
      if (act_reg == frjm_pkg::ACT_READ) begin
        jitter_logged      <= 1'b0;
        period_ticks       <= '0;
        entry_valid        <= rd_valid;
        entry_period_ticks <= rd_period;
        entry_fps_q16      <= rd_rate;
      end else begin
        jitter_logged      <= logged_reg;
        period_ticks       <= period_reg;
        entry_valid        <= 1'b0;
        entry_period_ticks <= '0;
        entry_fps_q16      <= '0;
      end
    end
  end

  // A result carrying a history entry never reports a logged frame.
  `FRJM_ASSERT_NOW(a_read_result_clean, clk, rst, out_valid && entry_valid, !jitter_logged && period_ticks == '0, "read result carries frame fields")
  // The divider only runs after the multipliers have finished.
  `FRJM_ASSERT_NOW(a_units_exclusive, clk, rst, div_stat.busy, !mul_per_stat.busy && !mul_rate_stat.busy && !mul_lim_stat.busy, "divider overlaps multipliers")
  // The sequencer waits in the multiply step only while the units run.
  `FRJM_ASSERT_NOW(a_mul_active, clk, rst, state == S_MUL, mul_per_stat.busy || mul_per_stat.done, "multiply step without active multiplier")
  // A new result appears only from the final step of an item.
  `FRJM_ASSERT_NEXT(a_load_from_done, clk, rst, !out_valid && state != S_DONE, !out_valid, "result loaded outside the final step")

endmodule

`default_nettype wire

### rtl/frjm_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none

module frjm_mul #(
  parameter int A_W = 32,
  parameter int B_W = frjm_pkg::CNT_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [A_W-1:0]         a,
  input  wire logic [B_W-1:0]         b,
  output logic      [A_W+B_W-1:0]     product,
  output frjm_pkg::frjm_unit_stat_t   stat
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_reg;
  logic [B_W-1:0]   b_sr;
  logic [P_W-1:0]   acc;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [P_W-1:0]   addend;

  // Multiplier bits are consumed most significant first.
  assign addend = b_sr[B_W-1] ? P_W'(a_reg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(B_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sr  <= b;
      acc   <= '0;
    end else if (busy) begin
      acc  <= {acc[P_W-2:0], 1'b0} + addend;
      b_sr <= {b_sr[B_W-2:0], 1'b0};
    end
  end

  assign product   = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### rtl/frjm_div.sv
// Radix-2 restoring divider with a saturating quotient, one bit per cycle.
`default_nettype none

module frjm_div #(
  parameter int NUM_W = frjm_pkg::NUM_W,
  parameter int DEN_W = frjm_pkg::TIME_BITS_DEF,
  parameter int Q_W   = frjm_pkg::RATE_W
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [NUM_W-1:0]       num,
  input  wire logic [DEN_W-1:0]       den,
  output logic      [Q_W-1:0]         quotient,
  output frjm_pkg::frjm_unit_stat_t   stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sr;
  logic [DEN_W-1:0] den_reg;
  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   q;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   trial_sub;

  assign trial     = {rem, num_sr[NUM_W-1]};
  assign fits      = trial >= {1'b0, den_reg};
  assign trial_sub = trial - {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Any quotient bit pushed out of the top marks the result as saturated.
  always_ff @(posedge clk) begin
    if (start) begin
      num_sr  <= num;
      den_reg <= den;
      rem     <= '0;
      q       <= '0;
      ovf     <= 1'b0;
    end else if (busy) begin
      num_sr <= {num_sr[NUM_W-2:0], 1'b0};
      rem    <= fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      q      <= {q[Q_W-2:0], fits};
      ovf    <= ovf | q[Q_W-1];
    end
  end

  assign quotient  = ovf ? '1 : q;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for the frame rate and jitter monitor.
`timescale 1ns / 1ps

module testbench;

  localparam int TW = frjm_pkg::TIME_BITS_DEF;
  localparam int QD = frjm_pkg::QUEUE_DEPTH_DEF;
  localparam int RW = frjm_pkg::RATE_W;
  localparam int IW = frjm_pkg::RIDX_W;

  // One input item as the driver presents it.
  typedef struct {
    logic          act;
    logic [TW-1:0] ts;
    logic [IW-1:0] idx;
  } event_item_t;

  // One result item, field for field as the block reports it.
  typedef struct {
    logic [RW-1:0] fps;
    logic          logged;
    logic [TW-1:0] period;
    logic          valid;
    logic [TW-1:0] e_period;
    logic [RW-1:0] e_fps;
  } monitor_report_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = frjm_pkg::REG_TPS;
  logic [TW-1:0] cfg_data = '0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          action = frjm_pkg::ACT_FRAME;
  logic [TW-1:0] timestamp = '0;
  logic [IW-1:0] read_index = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [RW-1:0] fps_q16;
  logic          jitter_logged;
  logic [TW-1:0] period_ticks;
  logic          entry_valid;
  logic [TW-1:0] entry_period_ticks;
  logic [RW-1:0] entry_fps_q16;

  frame_rate_jitter_monitor u_dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .action             (action),
    .timestamp          (timestamp),
    .read_index         (read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .fps_q16            (fps_q16),
    .jitter_logged      (jitter_logged),
    .period_ticks       (period_ticks),
    .entry_valid        (entry_valid),
    .entry_period_ticks (entry_period_ticks),
    .entry_fps_q16      (entry_fps_q16)
  );

  always #4 clk = ~clk;

  // Items waiting to be driven, reports waiting to come out of the block.
  event_item_t     queued_events[$];
  monitor_report_t awaited_reports[$];
  event_item_t     next_event;
  monitor_report_t got_report;
  int              fail_count = 0;
  // While set, neither side idles: this gives the long back-to-back stretch.
  logic            steady = 1'b0;
  // Running timestamp of the well-formed frame sequence.
  logic [TW-1:0]   ts_now = '0;

  // Shadow copy of the registers, at their reset values.
  logic [31:0]   m_tps     = frjm_pkg::TPS_RESET;
  logic [TW-1:0] m_window  = TW'(frjm_pkg::WINDOW_RESET);
  logic [15:0]   m_limit   = frjm_pkg::LIMIT_RESET;
  logic [TW-1:0] m_expiry  = TW'(frjm_pkg::EXPIRY_RESET);

  // Shadow copy of the block's state, all zero after reset.
  logic [15:0]   m_count     = '0;
  logic [TW-1:0] m_win_start = '0;
  logic [TW-1:0] m_last      = '0;
  logic [RW-1:0] m_rate      = '0;
  logic [15:0]   m_win_count = '0;
  logic [TW-1:0] m_win_delta = '0;
  logic          m_hvalid[QD] = '{default: 1'b0};
  logic [TW-1:0] m_htime[QD]  = '{default: '0};
  logic [TW-1:0] m_hperiod[QD] = '{default: '0};
  logic [RW-1:0] m_hrate[QD]  = '{default: '0};

  // Works out the report for one accepted item and advances the shadow state.
  function automatic monitor_report_t next_report(logic act, logic [TW-1:0] ts,
                                                  logic [IW-1:0] idx);
    monitor_report_t r;
    logic [TW-1:0]   elapsed;
    logic [TW-1:0]   period;
    logic [63:0]     num;
    logic [63:0]     quo;
    logic [127:0]    prod;
    logic [127:0]    diff;
    logic [127:0]    lhs;
    logic [127:0]    rhs;
    logic            hit;
    r = '{default: '0};
    if (act == frjm_pkg::ACT_READ) begin
      // A read only looks at the history; slots past the end read as zero.
      r.fps = m_rate;
      if (idx < QD) begin
        r.valid    = m_hvalid[idx];
        r.e_period = m_hperiod[idx];
        r.e_fps    = m_hrate[idx];
      end
      return r;
    end
    if (m_count != 16'hFFFF) m_count = m_count + 16'd1;
    // The rate window closes only on a forward, nonzero, long enough span.
    if (ts >= m_win_start) begin
      elapsed = ts - m_win_start;
      if (elapsed != '0 && elapsed >= m_window) begin
        num = 64'(m_count) * 64'(m_tps) * 64'd65536;
        quo = num / 64'(elapsed);
        m_rate      = (quo > 64'hFFFF_FFFF) ? '1 : quo[RW-1:0];
        m_win_count = m_count;
        m_win_delta = elapsed;
        m_count     = '0;
        m_win_start = ts;
      end
    end
    period = ts - m_last;
    // Entries stamped later than this frame are left alone.
    for (int i = 0; i < QD; i++) begin
      if (m_hvalid[i] && ts >= m_htime[i] && (ts - m_htime[i]) > m_expiry)
        m_hvalid[i] = 1'b0;
    end
    prod = 128'(period) * 128'(m_win_count);
    diff = (prod >= 128'(m_win_delta)) ? prod - 128'(m_win_delta)
                                       : 128'(m_win_delta) - prod;
    lhs  = diff << 16;
    rhs  = 128'(m_limit) * 128'(m_win_delta);
    hit  = (lhs >= rhs);
    if (hit) begin
      for (int i = 0; i < QD - 1; i++) begin
        m_hvalid[i]  = m_hvalid[i+1];
        m_htime[i]   = m_htime[i+1];
        m_hperiod[i] = m_hperiod[i+1];
        m_hrate[i]   = m_hrate[i+1];
      end
      m_hvalid[QD-1]  = 1'b1;
      m_htime[QD-1]   = ts;
      m_hperiod[QD-1] = period;
      m_hrate[QD-1]   = m_rate;
    end
    m_last   = ts;
    r.fps    = m_rate;
    r.logged = hit;
    r.period = period;
    return r;
  endfunction

  // Driver: presents queued items and predicts each one as it is accepted.
  // The ports still hold the accepted item here, since the new values are
  // nonblocking and land after this edge.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      action     <= frjm_pkg::ACT_FRAME;
      timestamp  <= '0;
      read_index <= '0;
    end else begin
      if (in_valid && in_ready)
        awaited_reports.push_back(next_report(action, timestamp, read_index));
      if (!in_valid || in_ready) begin
        if (queued_events.size() != 0 && (steady || $urandom_range(99) >= 31)) begin
          next_event = queued_events.pop_front();
          action     <= next_event.act;
          timestamp  <= next_event.ts;
          read_index <= next_event.idx;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: takes result items and compares them with the oldest report.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: result item with no report awaited, fps_q16 %0h", $time, fps_q16);
          fail_count++;
        end else begin
          got_report = awaited_reports.pop_front();
          check_field("fps_q16", 64'(got_report.fps), 64'(fps_q16));
          check_field("jitter_logged", 64'(got_report.logged), 64'(jitter_logged));
          check_field("period_ticks", 64'(got_report.period), 64'(period_ticks));
          check_field("entry_valid", 64'(got_report.valid), 64'(entry_valid));
          check_field("entry_period_ticks", 64'(got_report.e_period),
                      64'(entry_period_ticks));
          check_field("entry_fps_q16", 64'(got_report.e_fps), 64'(entry_fps_q16));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 31);
    end
  end

  function automatic void push_frame(logic [TW-1:0] ts);
    event_item_t e;
    e.act = frjm_pkg::ACT_FRAME;
    e.ts  = ts;
    e.idx = IW'($urandom_range(15));
    queued_events.push_back(e);
  endfunction

  function automatic void push_read(logic [IW-1:0] idx);
    event_item_t e;
    e.act = frjm_pkg::ACT_READ;
    e.ts  = TW'({$urandom, $urandom});
    e.idx = idx;
    queued_events.push_back(e);
  endfunction

  // Waits until every item has gone in and every report has come out.
  task automatic wait_idle();
    do @(negedge clk);
    while (queued_events.size() != 0 || in_valid || awaited_reports.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [TW-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      frjm_pkg::REG_TPS:    m_tps    = data[31:0];
      frjm_pkg::REG_WINDOW: m_window = data;
      frjm_pkg::REG_LIMIT:  m_limit  = data[15:0];
      default:              m_expiry = data;
    endcase
  endtask

  // Registers change only once the block has drained.
  task automatic set_regs(logic [31:0] tps, logic [TW-1:0] window, logic [15:0] limit,
                          logic [TW-1:0] expiry);
    wait_idle();
    write_reg(frjm_pkg::REG_TPS, TW'(tps));
    write_reg(frjm_pkg::REG_WINDOW, window);
    write_reg(frjm_pkg::REG_LIMIT, TW'(limit));
    write_reg(frjm_pkg::REG_EXPIRY, expiry);
  endtask

  // Mostly a steady frame sequence around the given period with some jitter
  // and the odd long gap, mixed with history reads, random timestamps and
  // frames that step backwards.
  task automatic queue_traffic(int n, int unsigned base);
    int unsigned r;
    int unsigned step;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 14) begin
        push_read(IW'($urandom_range(15)));
      end else if (r < 18) begin
        push_frame(TW'({$urandom, $urandom}));
      end else if (r < 23) begin
        push_frame(ts_now - TW'($urandom_range(base)));
      end else begin
        r = $urandom_range(99);
        if (r < 50)
          step = base;
        else if (r < 85)
          step = base - base / 16 + $urandom_range(base / 8);
        else
          step = base * $urandom_range(4) + $urandom_range(base);
        ts_now = ts_now + TW'(step);
        push_frame(ts_now);
      end
    end
  endtask

  initial begin
    logic [TW-1:0] window_r;
    logic [TW-1:0] burst_ts;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Empty history at reset, then a slot past the end.
    push_read(IW'(QD - 1));
    push_read(4'd15);
    // No elapsed time on the first frame, and every frame is logged until
    // the first window closes.
    push_frame(48'd0);
    push_frame(48'd1000);
    push_frame(48'd2000000);
    // This one closes the first window.
    push_frame(48'd5000000);
    push_frame(48'd5166667);
    push_frame(48'd5333334);
    push_frame(48'd5400000);
    // Backwards past the last frame: the period wraps.
    push_frame(48'd5200000);
    // Before the window start: no rate update.
    push_frame(48'd4000000);
    push_read(IW'(QD - 1));
    push_read(4'd0);
    push_read(4'd12);

    // Zero rate, zero window, widest limit, immediate expiry.
    set_regs(32'd0, 48'd0, 16'hFFFF, 48'd0);
    push_frame(48'd4000000);
    // Zero elapsed span leaves the rate alone even with a zero window.
    push_frame(48'd5000000);
    push_frame(48'd5000010);
    // Entries stamped after this frame do not expire.
    push_frame(48'd4000001);
    push_read(IW'(QD - 1));
    push_read(IW'(QD - 2));

    // Reset register values apart from a shorter window, with a display-like frame period.
    set_regs(32'd10_000_000, 48'd2_000_000, 16'd1966, 48'd30_000_000);
    ts_now = 48'd6_000_000;
    queue_traffic(190, 166667);

    // Fastest counter, shortest window, no threshold, no lifetime.
    set_regs(32'hFFFF_FFFF, 48'd1, 16'd0, 48'd0);
    queue_traffic(190, 1000);

    // Stopped counter, zero window, widest threshold, entries never expire.
    set_regs(32'd0, 48'd0, 16'hFFFF, '1);
    queue_traffic(190, 5000);

    // Random register values, frame period tied to the window.
    window_r = TW'({$urandom, $urandom}) >> $urandom_range(40, 22);
    set_regs($urandom, window_r, 16'($urandom),
             TW'({$urandom, $urandom}) >> $urandom_range(47, 18));
    queue_traffic(190, 32'(window_r / 6) + 1);

    // A back-to-back run of frames inside a window that never closes, then
    // one frame that closes it with the fastest counter so that the rate
    // saturates.
    set_regs(32'd1000, '1, 16'd1966, 48'd30_000_000);
    steady = 1'b1;
    burst_ts = m_win_start;
    for (int k = 0; k < 24; k++) begin
      burst_ts = burst_ts + TW'(1);
      push_frame(burst_ts);
    end
    set_regs(32'hFFFF_FFFF, 48'd1, 16'd1966, 48'd30_000_000);
    steady = 1'b0;
    push_frame(burst_ts + TW'(1));
    push_read(IW'(QD - 1));
    ts_now = burst_ts + TW'(1);

    // Timestamps run up to the top of the range and wrap past zero.
    set_regs(32'd1_000_000, 48'd50_000, 16'd20000, 48'd400_000);
    ts_now = '1 - TW'(60 * 7000);
    queue_traffic(190, 7000);

    // Random register values once more.
    window_r = TW'({$urandom, $urandom}) >> $urandom_range(40, 22);
    set_regs($urandom, window_r, 16'($urandom),
             TW'({$urandom, $urandom}) >> $urandom_range(47, 18));
    ts_now = TW'($urandom);
    queue_traffic(190, 32'(window_r / 6) + 1);

    wait_idle();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && awaited_reports.size() == 0) begin
      $display("frame_rate_jitter_monitor test passed");
    end else begin
      $display("frame_rate_jitter_monitor test failed");
    end
    $finish;
  end

  // Generous bound well past the slowest correct run.
  initial begin
    #(10_000_000);
    $display("frame_rate_jitter_monitor test failed");
    $finish;
  end

endmodule
